// ===== design/depe_pkg.sv =====
package depe_pkg;

    // Field widths
    localparam int unsigned PIX_W   = 8;
    localparam int unsigned CLASS_W = 2;
    // Working width for differences and rebuilt pixels (covers -511..511)
    localparam int unsigned WORK_W  = 12;

    // Largest pixel value
    localparam logic [PIX_W-1:0] MAX_PIX = 8'(256 - 1);

    // Pair class codes
    localparam logic [CLASS_W-1:0] CLS_NEITHER    = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_CHANGEABLE = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_SHIFTED    = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_EXPANDED   = 2'd3;

    // One input pixel pair with its payload bit
    typedef struct packed {
        logic             embed_bit;
        logic [PIX_W-1:0] pixel_b;
        logic [PIX_W-1:0] pixel_a;
    } t_pair_in;

    // One embedded result
    typedef struct packed {
        logic               range_error;
        logic               saved_lsb;
        logic               overflow_map_bit;
        logic               bit_consumed;
        logic [CLASS_W-1:0] pair_class;
        logic [PIX_W-1:0]   out_pixel_b;
        logic [PIX_W-1:0]   out_pixel_a;
    } t_pair_out;

endpackage

// ===== design/depe_in_stage.sv =====
module depe_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  depe_pkg::t_pair_in i_pair,
    output logic              o_valid,
    input  logic              i_ready,
    output depe_pkg::t_pair_in o_pair
);
    import depe_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_pair_in r_pair;
    t_pair_in n_pair;

    // Take a new transaction whenever the held one moves on or none is held
    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        n_pair  = r_pair;
        if (o_ready) begin
            n_valid = i_valid;
            n_pair  = i_pair;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_pair <= n_pair;
    end

    assign o_valid = r_valid;
    assign o_pair  = r_pair;

endmodule

// ===== design/depe_core.sv =====
module depe_core (
    input  depe_pkg::t_pair_in           i_pair,
    input  logic [depe_pkg::PIX_W-1:0]   i_delta,
    output depe_pkg::t_pair_out          o_result
);
    import depe_pkg::*;

    // |v| <= m, with v signed and m unsigned
    function automatic logic fits(input logic signed [WORK_W-1:0] v,
                                  input logic [PIX_W+1:0] m);
        logic signed [WORK_W-1:0] av;
        av = (v < 0) ? -v : v;
        return $unsigned(av) <= {{(WORK_W-PIX_W-2){1'b0}}, m};
    endfunction

    logic [PIX_W:0]           sum;
    logic [PIX_W-1:0]         mean;
    logic signed [WORK_W-1:0] l_s;
    logic signed [WORK_W-1:0] h;
    logic signed [WORK_W-1:0] d_s;
    logic [PIX_W+1:0]         m1;
    logic [PIX_W+1:0]         m2;
    logic [PIX_W+1:0]         lim;
    logic signed [WORK_W-1:0] h2;
    logic signed [WORK_W-1:0] h2p1;
    logic signed [WORK_W-1:0] fh2;
    logic signed [WORK_W-1:0] fh2p1;
    logic                     expandable;
    logic                     changeable;
    logic                     inside_delta;
    logic signed [WORK_W-1:0] h_shift;
    logic signed [WORK_W-1:0] hn;
    logic signed [WORK_W-1:0] hn_p1;
    logic signed [WORK_W-1:0] na;
    logic signed [WORK_W-1:0] nb;
    logic [CLASS_W-1:0]       cls;
    logic                     lsb;

    // Difference, floored mean and range limit
    always_comb begin
        sum  = {1'b0, i_pair.pixel_a} + {1'b0, i_pair.pixel_b};
        mean = sum[PIX_W:1];
        l_s  = $signed({{(WORK_W-PIX_W){1'b0}}, mean});
        h    = $signed({{(WORK_W-PIX_W){1'b0}}, i_pair.pixel_a})
             - $signed({{(WORK_W-PIX_W){1'b0}}, i_pair.pixel_b});
        d_s  = $signed({{(WORK_W-PIX_W){1'b0}}, i_delta});
        m1   = {1'b0, MAX_PIX - mean, 1'b0};
        m2   = {1'b0, mean, 1'b1};
        lim  = (m1 < m2) ? m1 : m2;
    end

    // Classify the pair
    always_comb begin
        h2           = {h[WORK_W-2:0], 1'b0};
        h2p1         = {h[WORK_W-2:0], 1'b1};
        fh2          = {h[WORK_W-1:1], 1'b0};
        fh2p1        = {h[WORK_W-1:1], 1'b1};
        expandable   = fits(h2, lim) && fits(h2p1, lim);
        changeable   = fits(fh2, lim) && fits(fh2p1, lim);
        inside_delta = (h >= -d_s - 12'sd1) && (h <= d_s);
        h_shift      = (h > d_s) ? (h + d_s + 12'sd1) : (h - d_s - 12'sd1);
    end

    // Form the new difference
    always_comb begin
        hn  = h;
        cls = CLS_NEITHER;
        lsb = 1'b0;
        if (expandable) begin
            if (inside_delta) begin
                cls = CLS_EXPANDED;
                hn  = {h[WORK_W-2:0], i_pair.embed_bit};
            end else begin
                cls = CLS_SHIFTED;
                lsb = h_shift[0];
                hn  = {h_shift[WORK_W-1:1], i_pair.embed_bit};
            end
        end else if (changeable) begin
            cls = CLS_CHANGEABLE;
            lsb = h[0];
            hn  = {h[WORK_W-1:1], i_pair.embed_bit};
        end
    end

    // Rebuild the pair and flag values outside the pixel range
    always_comb begin
        hn_p1 = hn + 12'sd1;
        na    = l_s + (hn_p1 >>> 1);
        nb    = l_s - (hn >>> 1);

        o_result.out_pixel_a      = na[PIX_W-1:0];
        o_result.out_pixel_b      = nb[PIX_W-1:0];
        o_result.pair_class       = cls;
        o_result.bit_consumed     = (cls != CLS_NEITHER);
        o_result.overflow_map_bit = (cls == CLS_SHIFTED) || (cls == CLS_EXPANDED);
        o_result.saved_lsb        = lsb;
        o_result.range_error      = (na[WORK_W-1:PIX_W] != '0) || (nb[WORK_W-1:PIX_W] != '0);
    end

endmodule

// ===== design/difference_expansion_pair_embed_unit.sv =====
// Pipeline: two register stages, the input register and then the result register; a result
// is offered once its input transaction has passed through both.
// Throughput: one pixel pair per cycle; the input register and the result register
// both advance whenever the result register is empty or being drained.
// Reset: synchronous, active low; clears both valid flags and sets shift_delta to 0.
module difference_expansion_pair_embed_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: shift_delta
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    // Input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] pixel_a, [15:8] pixel_b, [16] embed_bit, [23:17] zero
    input  logic [23:0] i_s_axis_tdata,
    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] out_pixel_a, [15:8] out_pixel_b, [17:16] pair_class, [18] bit_consumed,
    // [19] overflow_map_bit, [20] saved_lsb, [21] range_error, [23:22] zero
    output logic [23:0] o_m_axis_tdata
);
    import depe_pkg::*;

    localparam int unsigned IN_BITS  = $bits(t_pair_in);
    localparam int unsigned OUT_BITS = $bits(t_pair_out);

    logic [PIX_W-1:0] r_delta;
    logic             r_out_valid;
    logic             n_out_valid;
    t_pair_out        r_out;
    t_pair_out        n_out;
    t_pair_in         in_pair;
    t_pair_in         held_pair;
    t_pair_out        result;
    logic             held_valid;
    logic             out_ready;

    // Hold the threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta <= '0;
        end else if (i_cfg_we) begin
            r_delta <= i_cfg_wdata;
        end
    end

    assign in_pair = t_pair_in'(i_s_axis_tdata[IN_BITS-1:0]);

    depe_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_pair  (in_pair),
        .o_valid (held_valid),
        .i_ready (out_ready),
        .o_pair  (held_pair)
    );

    depe_core u_core (
        .i_pair   (held_pair),
        .i_delta  (r_delta),
        .o_result (result)
    );

    // Advance the result register when it is empty or its transaction is taken
    assign out_ready = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (out_ready) begin
            n_out_valid = held_valid;
            n_out       = result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(24-OUT_BITS){1'b0}}, r_out};

endmodule
